// ===== rtl/sigt_pkg.sv =====
`timescale 1ns / 1ps

package sigt_pkg;

   localparam int SEQ_W          = 32;
   localparam int HANDLE_W       = 32;
   localparam int SIZE_FIELD_W   = 4;
   localparam int CSR_W          = 4;
   localparam logic [CSR_W-1:0] RESET_SIZE_LOG2 = 4'd4;

   typedef enum logic [1:0] {
      REQ_SET        = 2'd0,
      REQ_GET        = 2'd1,
      REQ_GET_STORED = 2'd2,
      REQ_REMOVE     = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_code_type;

   // Source of the response payload.
   typedef enum logic [1:0] {
      RSP_ENTRY    = 2'd0,   // entry read from the table
      RSP_REQ      = 2'd1,   // item of the request just stored
      RSP_MISS     = 2'd2,
      RSP_OVERFLOW = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         wr_lookup;
      logic         clr_lookup;
      logic         load_grow;
      logic         rd_walk;
      logic         wr_move;
      logic         clr_walk;
      logic         walk_next;
      logic         wr_new;
      logic         clr_step;
      logic         respond;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      req_code_type req_code;
      logic         occ;
      logic         match;
      logic         grow_ok;
      logic         move_needed;
      logic         walk_last;
      logic         clr_last;
   } sts_type;

endpackage

// ===== rtl/sigt_ctrl.sv =====
`timescale 1ns / 1ps

module sigt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             csr_we,
   input  sigt_pkg::sts_type sts,
   output sigt_pkg::cmd_type cmd,
   output logic             busy
);
   import sigt_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_LOOKUP = 7'b0000100,
      S_WREAD  = 7'b0001000,
      S_WCHECK = 7'b0010000,
      S_WCLR   = 7'b0100000,
      S_STORE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_IDLE;
            unique case (sts.req_code)
               REQ_SET: begin
                  if (!sts.occ || sts.match) begin
                     cmd.wr_lookup = 1'b1;
                     cmd.respond   = 1'b1;
                     cmd.rsp_kind  = RSP_REQ;
                  end else if (sts.grow_ok) begin
                     cmd.load_grow = 1'b1;
                     state_in      = S_WREAD;
                  end else begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_kind = RSP_OVERFLOW;
                  end
               end
               REQ_GET: begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_kind = sts.match ? RSP_ENTRY : RSP_MISS;
               end
               REQ_GET_STORED: begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_kind = sts.occ ? RSP_ENTRY : RSP_MISS;
               end
               REQ_REMOVE: begin
                  cmd.respond    = 1'b1;
                  cmd.clr_lookup = sts.match;
                  cmd.rsp_kind   = sts.match ? RSP_ENTRY : RSP_MISS;
               end
               default: begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_kind = RSP_MISS;
               end
            endcase
         end
         S_WREAD: begin
            cmd.rd_walk = 1'b1;
            state_in    = S_WCHECK;
         end
         S_WCHECK: begin
            if (sts.move_needed) begin
               cmd.wr_move = 1'b1;
               state_in    = S_WCLR;
            end else if (sts.walk_last) begin
               state_in = S_STORE;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_WREAD;
            end
         end
         S_WCLR: begin
            cmd.clr_walk = 1'b1;
            if (sts.walk_last) begin
               state_in = S_STORE;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_WREAD;
            end
         end
         S_STORE: begin
            cmd.wr_new   = 1'b1;
            cmd.respond  = 1'b1;
            cmd.rsp_kind = RSP_REQ;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // a size write restarts the clearing pass
      if (csr_we) state_in = S_CLEAR;
   end

   assign busy = (state_ff != S_IDLE);

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !cmd.respond)
      else $error("two responses in consecutive cycles");

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !csr_we) |=> (state_ff == S_LOOKUP))
      else $error("accepted transaction did not reach lookup");

   a_store_after_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STORE) |->
         ($past(state_ff) == S_WCHECK || $past(state_ff) == S_WCLR))
      else $error("store entered without a rehash walk");

endmodule

// ===== rtl/sigt_dpath.sv =====
`timescale 1ns / 1ps

module sigt_dpath #(
   parameter int MAX_SIZE_LOG2 = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sigt_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [1:0]                          req_type,
   input  logic [sigt_pkg::SEQ_W-1:0]          req_seq,
   input  logic [sigt_pkg::HANDLE_W-1:0]       req_value_handle,
   input  sigt_pkg::cmd_type                   cmd,
   output sigt_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_slot_occupied,
   output logic [sigt_pkg::SEQ_W-1:0]          rsp_entry_seq,
   output logic [sigt_pkg::HANDLE_W-1:0]       rsp_entry_handle,
   output logic [sigt_pkg::SIZE_FIELD_W-1:0]   rsp_size_log2_now
);
   import sigt_pkg::*;

   localparam int ADDR_W = MAX_SIZE_LOG2;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int LG_W   = $clog2(MAX_SIZE_LOG2 + 1);

   typedef struct packed {
      logic                valid;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   function automatic logic [ADDR_W-1:0] mask_of(input logic [LG_W-1:0] lg);
      mask_of = ~({ADDR_W{1'b1}} << lg);
   endfunction

   function automatic logic [LG_W-1:0] sat_size(input logic [CSR_W-1:0] v);
      if ({1'b0, v} > (CSR_W+1)'(MAX_SIZE_LOG2)) begin
         sat_size = LG_W'(MAX_SIZE_LOG2);
      end else begin
         sat_size = LG_W'(v);
      end
   endfunction

   // smallest size that separates two sequences: one above the lowest differing bit
   function automatic logic [LG_W-1:0] split_size(input logic [ADDR_W-1:0] diff);
      logic [LG_W-1:0] r;
      r = '0;
      for (int i = ADDR_W - 1; i >= 0; i--) begin
         if (diff[i]) r = LG_W'(i + 1);
      end
      split_size = r;
   endfunction

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   entry_type           wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   req_code_type        code_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [LG_W-1:0]     active_ff, active_in;
   logic [LG_W-1:0]     grow_lg_ff;
   logic [ADDR_W-1:0]   walk_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff;

   logic [ADDR_W-1:0]   idx;
   logic [ADDR_W-1:0]   diff;
   logic [ADDR_W-1:0]   move_dest;

   logic                     rsp_valid_ff;
   status_code_type          status_ff, status_in;
   logic                     occ_ff, occ_in;
   logic [SEQ_W-1:0]         eseq_ff, eseq_in;
   logic [HANDLE_W-1:0]      ehandle_ff, ehandle_in;
   logic [SIZE_FIELD_W-1:0]  size_ff, size_in;

   assign idx       = seq_ff[ADDR_W-1:0] & mask_of(active_ff);
   assign diff      = rd_data_ff.seq[ADDR_W-1:0] ^ seq_ff[ADDR_W-1:0];
   assign move_dest = rd_data_ff.seq[ADDR_W-1:0] & mask_of(grow_lg_ff);

   // table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      rd_en   = cmd.load_req | cmd.rd_walk;
      rd_addr = cmd.load_req ? (req_seq[ADDR_W-1:0] & mask_of(active_ff)) : walk_ff;
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.clr_step) begin
         wr_addr = clr_cnt_ff;
      end else if (cmd.wr_lookup) begin
         wr_addr = idx;
         wr_data = '{valid: 1'b1, seq: seq_ff, handle: handle_ff};
      end else if (cmd.clr_lookup) begin
         wr_addr = idx;
      end else if (cmd.wr_move) begin
         wr_addr = move_dest;
         wr_data = rd_data_ff;
      end else if (cmd.clr_walk) begin
         wr_addr = walk_ff;
      end else if (cmd.wr_new) begin
         wr_addr = seq_ff[ADDR_W-1:0] & mask_of(grow_lg_ff);
         wr_data = '{valid: 1'b1, seq: seq_ff, handle: handle_ff};
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         code_ff   <= req_code_type'(req_type);
         seq_ff    <= req_seq;
         handle_ff <= req_value_handle;
      end
      if (cmd.load_grow) grow_lg_ff <= split_size(diff);
   end

   always_comb begin
      active_in = active_ff;
      if (csr_we) begin
         active_in = sat_size(csr_wdata);
      end else if (cmd.wr_new) begin
         active_in = grow_lg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= sat_size(RESET_SIZE_LOG2);
         clr_cnt_ff <= '0;
         walk_ff    <= '0;
      end else begin
         active_ff <= active_in;
         if (csr_we) begin
            clr_cnt_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.load_grow) begin
            walk_ff <= '0;
         end else if (cmd.walk_next) begin
            walk_ff <= walk_ff + 1'b1;
         end
      end
   end

   always_comb begin
      sts.req_code    = code_ff;
      sts.occ         = rd_data_ff.valid;
      sts.match       = rd_data_ff.valid && (rd_data_ff.seq == seq_ff);
      sts.grow_ok     = |diff;
      sts.move_needed = rd_data_ff.valid && (move_dest != walk_ff);
      sts.walk_last   = (walk_ff == mask_of(active_ff));
      sts.clr_last    = (clr_cnt_ff == {ADDR_W{1'b1}});
   end

   always_comb begin
      status_in  = ST_DONE;
      occ_in     = 1'b1;
      eseq_in    = rd_data_ff.seq;
      ehandle_in = rd_data_ff.handle;
      size_in    = SIZE_FIELD_W'(active_in);
      case (cmd.rsp_kind)
         RSP_ENTRY: begin
         end
         RSP_REQ: begin
            eseq_in    = seq_ff;
            ehandle_in = handle_ff;
         end
         RSP_MISS: begin
            status_in  = ST_NOT_FOUND;
            occ_in     = 1'b0;
            eseq_in    = '0;
            ehandle_in = '0;
         end
         default: begin
            status_in  = ST_OVERFLOW;
            occ_in     = 1'b0;
            eseq_in    = '0;
            ehandle_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         status_ff  <= status_in;
         occ_ff     <= occ_in;
         eseq_ff    <= eseq_in;
         ehandle_ff <= ehandle_in;
         size_ff    <= size_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_slot_occupied = occ_ff;
   assign rsp_entry_seq     = eseq_ff;
   assign rsp_entry_handle  = ehandle_ff;
   assign rsp_size_log2_now = size_ff;

   a_grow_larger: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_grow && !csr_we) |=> (grow_lg_ff > active_ff))
      else $error("growth did not enlarge the table");

   a_overflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_OVERFLOW) |->
         (!occ_ff && eseq_ff == '0 && ehandle_ff == '0))
      else $error("overflow response carries an entry");

endmodule

// ===== rtl/sequence_indexed_growing_table.sv =====
`timescale 1ns / 1ps
// A request is accepted on start while busy and csr_we are low; its rsp_valid strobe follows
//   the lookup state and the response registers. Busy stays high through the lookup, so a
//   new lookup, store or remove is taken only once the last one's lookup state is done.
// A set that grows the table walks the old slots (read, check, move where needed), then stores.
// Reset (synchronous, active high) and every csr write run a clearing pass over all
//   2^MAX_SIZE_LOG2 slots with busy high. Responses cannot be stalled by the receiver.

module sequence_indexed_growing_table #(
   parameter int MAX_SIZE_LOG2 = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [sigt_pkg::SEQ_W-1:0]          req_seq,
   input  logic [sigt_pkg::HANDLE_W-1:0]       req_value_handle,
   // response channel
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_slot_occupied,
   output logic [sigt_pkg::SEQ_W-1:0]          rsp_entry_seq,
   output logic [sigt_pkg::HANDLE_W-1:0]       rsp_entry_handle,
   output logic [sigt_pkg::SIZE_FIELD_W-1:0]   rsp_size_log2_now,
   // size register: log2 of the starting table size, a write clears the table
   input  logic                                csr_we,
   input  logic [sigt_pkg::CSR_W-1:0]          csr_wdata
);
   import sigt_pkg::*;

   // Controller sequences each transaction (lookup, rehash walk, clearing pass);
   // the datapath owns the slot memory, size registers and response registers.
   cmd_type cmd;
   sts_type sts;

   sigt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .csr_we (csr_we),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Slots are addressed by the low active-size bits of the sequence. On growth
   // entries move in place: an entry at old slot i lands at i plus a multiple of
   // the old size, which is always an empty slot, so no scratch copy is needed.
   sigt_dpath #(
      .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_seq           (req_seq),
      .req_value_handle  (req_value_handle),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot_occupied (rsp_slot_occupied),
      .rsp_entry_seq     (rsp_entry_seq),
      .rsp_entry_handle  (rsp_entry_handle),
      .rsp_size_log2_now (rsp_size_log2_now)
   );

endmodule

// ===== test/sequence_indexed_growing_table_tb.sv =====
`timescale 1ns / 1ps

module sequence_indexed_growing_table_tb;
   import sigt_pkg::*;

   localparam int MAX_LG      = 10;
   localparam int TABLE_DEPTH = 1 << MAX_LG;
   // No transaction for this many cycles means the block hung. The slowest legal gap
   // is a grow out of 512 slots or a clearing pass.
   localparam int STALL_LIMIT = 20000;

   // One response as the block should report it.
   typedef struct packed {
      status_code_type   status;
      logic              occupied;
      logic [SEQ_W-1:0]  seq_out;
      logic [31:0]       handle_out;
      logic [3:0]        size_lg;
   } table_reply_type;

   // One row of the directed script: a size write or a request, the latter with an
   // optional hand-written expectation.
   typedef struct packed {
      logic            cfg_row;
      logic [3:0]      cfg_val;
      logic            typed;
      req_code_type    code;
      logic [31:0]     seq;
      logic [31:0]     handle;
      table_reply_type want;
   } step_type;

   // DUT pins; every input starts at a known value.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_type = 2'd0;
   logic [SEQ_W-1:0]      req_seq = '0;
   logic [HANDLE_W-1:0]   req_value_handle = '0;
   logic                  rsp_valid;
   logic [1:0]            rsp_status;
   logic                  rsp_slot_occupied;
   logic [SEQ_W-1:0]      rsp_entry_seq;
   logic [HANDLE_W-1:0]   rsp_entry_handle;
   logic [SIZE_FIELD_W-1:0] rsp_size_log2_now;
   logic                  csr_we = 1'b0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // Shadow copy of the table, kept in step with every accepted transaction.
   bit          tbl_live   [TABLE_DEPTH];
   logic [31:0] tbl_seq    [TABLE_DEPTH];
   logic [31:0] tbl_handle [TABLE_DEPTH];
   bit          old_live   [TABLE_DEPTH];
   logic [31:0] old_seq    [TABLE_DEPTH];
   logic [31:0] old_handle [TABLE_DEPTH];
   int unsigned live_size_lg;
   logic [3:0]  size_reg;

   table_reply_type pending_replies[$];   // expected responses, oldest first
   logic [31:0]     recent_seqs[$];       // seqs stored lately, reused to hit and collide
   step_type        directed_steps[$];

   // Expectation riding along with the request currently on the pins.
   bit              row_typed = 1'b0;
   table_reply_type row_want = '0;

   int unsigned fail_count   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned n_accepted   = 0;
   int unsigned n_hits       = 0;
   int unsigned n_grows      = 0;
   int unsigned n_overflows  = 0;
   int unsigned peak_lg      = 0;

   sequence_indexed_growing_table #(
      .MAX_SIZE_LOG2(MAX_LG)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_seq           (req_seq),
      .req_value_handle  (req_value_handle),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot_occupied (rsp_slot_occupied),
      .rsp_entry_seq     (rsp_entry_seq),
      .rsp_entry_handle  (rsp_entry_handle),
      .rsp_size_log2_now (rsp_size_log2_now),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Table predictor
   // ------------------------------------------------------------------

   // Size register write or reset: empty table, size saturates at the built capacity.
   task automatic clear_model();
      live_size_lg = (size_reg > MAX_LG) ? MAX_LG : size_reg;
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_live[i] = 1'b0;
      if (live_size_lg > peak_lg) peak_lg = live_size_lg;
   endtask

   task automatic predict_table_op(input req_code_type code, input logic [31:0] s,
                                   input logic [31:0] h, output table_reply_type r);
      logic [31:0] mask;
      int unsigned idx;
      int unsigned lg;
      int unsigned old_n;
      int unsigned dst;
      bit          occ;
      bit          hit;
      mask = (32'd1 << live_size_lg) - 32'd1;
      idx  = s & mask;
      occ  = tbl_live[idx];
      hit  = occ && (tbl_seq[idx] == s);
      // miss fields by default: not found, everything zero
      r = '0;
      r.status = ST_NOT_FOUND;
      case (code)
         REQ_SET: begin
            if (!occ || hit) begin
               tbl_live[idx]   = 1'b1;
               tbl_seq[idx]    = s;
               tbl_handle[idx] = h;
               r.status = ST_DONE; r.occupied = 1'b1; r.seq_out = s; r.handle_out = h;
            end else begin
               // double until the resident and the new seq land in different slots
               lg = live_size_lg;
               while (lg <= MAX_LG && ((tbl_seq[idx] ^ s) & ((32'd1 << lg) - 32'd1)) == 0)
                  lg++;
               if (lg > MAX_LG) begin
                  r.status = ST_OVERFLOW;
                  n_overflows++;
               end else begin
                  old_n = 1 << live_size_lg;
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     old_live[i]   = tbl_live[i];
                     old_seq[i]    = tbl_seq[i];
                     old_handle[i] = tbl_handle[i];
                     tbl_live[i]   = 1'b0;
                  end
                  live_size_lg = lg;
                  mask = (32'd1 << lg) - 32'd1;
                  dst = s & mask;
                  tbl_live[dst] = 1'b1; tbl_seq[dst] = s; tbl_handle[dst] = h;
                  // rehash every old entry into the wider index space
                  for (int i = 0; i < old_n; i++) begin
                     if (old_live[i]) begin
                        dst = old_seq[i] & mask;
                        tbl_live[dst]   = 1'b1;
                        tbl_seq[dst]    = old_seq[i];
                        tbl_handle[dst] = old_handle[i];
                     end
                  end
                  n_grows++;
                  if (lg > peak_lg) peak_lg = lg;
                  r.status = ST_DONE; r.occupied = 1'b1; r.seq_out = s; r.handle_out = h;
               end
            end
         end
         REQ_GET, REQ_GET_STORED, REQ_REMOVE: begin
            // get and remove need a seq match, get-stored takes whatever sits in the slot
            if (code == REQ_GET_STORED ? occ : hit) begin
               r.status = ST_DONE; r.occupied = 1'b1;
               r.seq_out = tbl_seq[idx]; r.handle_out = tbl_handle[idx];
               if (code == REQ_REMOVE) tbl_live[idx] = 1'b0;
               n_hits++;
            end
         end
      endcase
      r.size_lg = live_size_lg[3:0];
   endtask

   // ------------------------------------------------------------------
   // Monitor: all sampling at the rising edge, before the DUT's flops update
   // ------------------------------------------------------------------

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      table_reply_type want;
      table_reply_type model_reply;
      if (reset) begin
         size_reg = RESET_SIZE_LOG2;
         clear_model();
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         // responses first: one accepted this edge cannot belong to a request of this edge
         if (rsp_valid) begin
            quiet_cycles = 0;
            if (pending_replies.size() == 0) begin
               fail_count++;
               $display("%0t: response with nothing pending: expected none, got status %0d seq %h",
                        $time, rsp_status, rsp_entry_seq);
            end else begin
               want = pending_replies.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("slot_occupied", want.occupied, rsp_slot_occupied);
               check_field("entry_seq", want.seq_out, rsp_entry_seq);
               check_field("entry_handle", want.handle_out, rsp_entry_handle);
               check_field("size_log2_now", want.size_lg, rsp_size_log2_now);
            end
         end
         if (csr_we) begin
            size_reg = csr_wdata;
            clear_model();
         end
         if (start && !busy) begin
            quiet_cycles = 0;
            n_accepted++;
            predict_table_op(req_code_type'(req_type), req_seq, req_value_handle, model_reply);
            // hand-written rows override the predictor, which still tracks the state
            pending_replies.push_back(row_typed ? row_want : model_reply);
         end
      end
   end

   // Watchdog: the whole run stops if no transaction moves for too long.
   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
               $time, STALL_LIMIT, pending_replies.size());
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: pins change on the falling edge only
   // ------------------------------------------------------------------

   // Holds start until the transaction is taken; start stays high on return so that a
   // back-to-back request needs no drop in between.
   task automatic issue(input req_code_type code, input logic [31:0] s, input logic [31:0] h,
                        input bit typed, input table_reply_type want);
      @(negedge clock);
      start            = 1'b1;
      req_type         = code;
      req_seq          = s;
      req_value_handle = h;
      row_typed        = typed;
      row_want         = want;
      do @(posedge clock); while (busy);
   endtask

   // One idle cycle; the payload pins carry junk that must be ignored.
   task automatic rest();
      @(negedge clock);
      start            = 1'b0;
      req_type         = $urandom_range(0, 3);
      req_seq          = $urandom;
      req_value_handle = $urandom;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   // Only called with the table idle; the clearing pass that follows shows up as busy.
   task automatic write_size(input logic [3:0] v);
      @(negedge clock);
      start     = 1'b0;
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic step_type op(input req_code_type c, input logic [31:0] s,
                                   input logic [31:0] h);
      step_type t;
      t = '0;
      t.code = c; t.seq = s; t.handle = h;
      return t;
   endfunction

   function automatic step_type op_want(input req_code_type c, input logic [31:0] s,
                                        input logic [31:0] h, input status_code_type st,
                                        input logic occ, input logic [31:0] es,
                                        input logic [31:0] eh, input logic [3:0] lg);
      step_type t;
      t = op(c, s, h);
      t.typed = 1'b1;
      t.want.status = st; t.want.occupied = occ;
      t.want.seq_out = es; t.want.handle_out = eh; t.want.size_lg = lg;
      return t;
   endfunction

   function automatic step_type size_write(input logic [3:0] v);
      step_type t;
      t = '0;
      t.cfg_row = 1'b1; t.cfg_val = v;
      return t;
   endfunction

   function automatic req_code_type pick_code();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return REQ_SET;
      if (r < 6) return REQ_GET;
      if (r < 8) return REQ_GET_STORED;
      return REQ_REMOVE;
   endfunction

   // Mostly seqs related to stored ones, so lookups hit and sets collide; the rest is noise.
   function automatic logic [31:0] pick_seq();
      logic [31:0] base;
      logic [31:0] noise;
      int unsigned mode;
      mode  = $urandom_range(0, 7);
      noise = $urandom;
      if (recent_seqs.size() == 0 || mode < 2) return noise;
      base = recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
      case (mode)
         5:       return {noise[31:10], base[9:0]};               // collides at every size
         6:       return base ^ (32'd1 << $urandom_range(0, 9));  // splits at a chosen size
         7:       return {noise[31:6], 6'($urandom_range(0, 63))};
         default: return base;
      endcase
   endfunction

   // Random traffic at one table size; idle_pct is the sender's idle chance per cycle.
   task automatic run_phase(input logic [3:0] size_lg, input int unsigned idle_pct,
                            input int unsigned count);
      req_code_type code;
      logic [31:0]  s;
      wait_drained();
      write_size(size_lg);
      for (int unsigned i = 0; i < count; i++) begin
         // once per phase hold off until the block has answered everything
         if (i == count / 2) wait_drained();
         // first quarter of every 64 goes back to back
         if ((i % 64) >= 16)
            while ($urandom_range(0, 99) < idle_pct) rest();
         code = pick_code();
         s    = pick_seq();
         if (code == REQ_SET) begin
            recent_seqs.push_back(s);
            if (recent_seqs.size() > 48) void'(recent_seqs.pop_front());
         end
         issue(code, s, $urandom, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      // After reset: size 4, empty table.
      directed_steps.push_back(op_want(REQ_GET, 32'h0, 32'h0, ST_NOT_FOUND, 0, 0, 0, 4));
      directed_steps.push_back(op_want(REQ_GET_STORED, 32'h0, 32'h0, ST_NOT_FOUND, 0, 0, 0, 4));
      directed_steps.push_back(op_want(REQ_REMOVE, 32'h0, 32'h0, ST_NOT_FOUND, 0, 0, 0, 4));
      directed_steps.push_back(op_want(REQ_SET, 32'h0, 32'h0, ST_DONE, 1, 32'h0, 32'h0, 4));
      directed_steps.push_back(op_want(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       ST_DONE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4));
      directed_steps.push_back(op_want(REQ_GET, 32'hFFFF_FFFF, 32'h0,
                                       ST_DONE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4));
      // same slot, other seq: get-stored returns the resident, get and remove miss
      directed_steps.push_back(op_want(REQ_GET_STORED, 32'hF, 32'h0,
                                       ST_DONE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4));
      directed_steps.push_back(op_want(REQ_GET, 32'hF, 32'h0, ST_NOT_FOUND, 0, 0, 0, 4));
      directed_steps.push_back(op_want(REQ_REMOVE, 32'hF, 32'h0, ST_NOT_FOUND, 0, 0, 0, 4));
      // overwrite with the same seq
      directed_steps.push_back(op_want(REQ_SET, 32'h0, 32'h1234, ST_DONE, 1, 32'h0, 32'h1234, 4));
      // slot 0 taken by seq 0: grows 16 -> 32 slots
      directed_steps.push_back(op_want(REQ_SET, 32'h10, 32'hA5A5_A5A5,
                                       ST_DONE, 1, 32'h10, 32'hA5A5_A5A5, 5));
      directed_steps.push_back(op(REQ_GET_STORED, 32'h1F, 32'h0));
      // low 10 bits equal: no size separates them, nothing stored
      directed_steps.push_back(op_want(REQ_SET, 32'h400, 32'h1, ST_OVERFLOW, 0, 0, 0, 5));
      directed_steps.push_back(op_want(REQ_REMOVE, 32'h10, 32'h0,
                                       ST_DONE, 1, 32'h10, 32'hA5A5_A5A5, 5));
      directed_steps.push_back(op_want(REQ_REMOVE, 32'h10, 32'h0, ST_NOT_FOUND, 0, 0, 0, 5));
      directed_steps.push_back(op(REQ_GET, 32'h0, 32'h0));
      // oversized register value saturates to the full table
      directed_steps.push_back(size_write(4'd15));
      directed_steps.push_back(op_want(REQ_GET_STORED, 32'h0, 32'h0, ST_NOT_FOUND, 0, 0, 0, 10));
      directed_steps.push_back(op_want(REQ_SET, 32'h3FF, 32'h5A5A_5A5A,
                                       ST_DONE, 1, 32'h3FF, 32'h5A5A_5A5A, 10));
      directed_steps.push_back(op_want(REQ_SET, 32'hFFFF_FFFF, 32'h7, ST_OVERFLOW, 0, 0, 0, 10));
      directed_steps.push_back(op(REQ_GET, 32'h3FF, 32'h0));
      // single-slot table: grows to 2, then straight to the full size
      directed_steps.push_back(size_write(4'd0));
      directed_steps.push_back(op_want(REQ_SET, 32'h1, 32'h1, ST_DONE, 1, 32'h1, 32'h1, 0));
      directed_steps.push_back(op_want(REQ_SET, 32'h0, 32'h2, ST_DONE, 1, 32'h0, 32'h2, 1));
      directed_steps.push_back(op_want(REQ_SET, 32'h200, 32'h3, ST_DONE, 1, 32'h200, 32'h3, 10));
      directed_steps.push_back(op(REQ_GET_STORED, 32'h1, 32'h0));

      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].cfg_row) begin
            wait_drained();
            write_size(directed_steps[i].cfg_val);
         end else begin
            issue(directed_steps[i].code, directed_steps[i].seq, directed_steps[i].handle,
                  directed_steps[i].typed, directed_steps[i].want);
         end
      end

      // sender idles 21%, then 45%, then never
      run_phase(4'd3, 21, 230);
      run_phase(4'd10, 45, 230);
      run_phase(4'd1, 0, 230);

      wait_drained();
      repeat (8) @(negedge clock);
      if (pending_replies.size() != 0) begin
         fail_count++;
         $display("%0t: responses missing: expected 0 outstanding, got %0d",
                  $time, pending_replies.size());
      end

      $display("tb: %0d transactions, %0d lookup/remove hits, %0d table growths (up to 2^%0d)",
               n_accepted, n_hits, n_grows, peak_lg);
      $display("tb: %0d overflows at capacity, sizes 2^0 to 2^10 and a saturated write",
               n_overflows);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sigt_pkg.sv
rtl/sigt_ctrl.sv
rtl/sigt_dpath.sv
rtl/sequence_indexed_growing_table.sv
test/sequence_indexed_growing_table_tb.sv
